// ===== rtl/dmet_pkg.sv =====
// Package for the device mode event tracker: codes, state encodings and shared structs.
package dmet_pkg;

    localparam int EPOCH_BITS_DEFAULT = 8;
    localparam int EPOCH_OUT_BITS     = 8;

    typedef enum logic [3:0] {
        OP_USB_ATTACH      = 4'd0,
        OP_USB_DETACH      = 4'd1,
        OP_LINK_STOPPED    = 4'd2,
        OP_LINK_DISCONN    = 4'd3,
        OP_LINK_CONNECTING = 4'd4,
        OP_LINK_ONLINE     = 4'd5,
        OP_PROV_START      = 4'd6,
        OP_PROV_SUCCESS    = 4'd7,
        OP_PROV_TIMEOUT    = 4'd8,
        OP_PROV_RESET      = 4'd9,
        OP_UPD_START       = 4'd10,
        OP_UPD_ABORT       = 4'd11,
        OP_UPD_FAIL        = 4'd12,
        OP_UPD_COMMIT      = 4'd13,
        OP_UPD_RESET       = 4'd14,
        OP_QUERY           = 4'd15
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_BAD_TRANSITION = 3'd1,
        ST_BAD_ARGUMENT   = 3'd2,
        ST_UNAUTH         = 3'd3,
        ST_BUSY           = 3'd4,
        ST_OFFLINE        = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        LINK_STOPPED    = 2'd0,
        LINK_DISCONN    = 2'd1,
        LINK_CONNECTING = 2'd2,
        LINK_ONLINE     = 2'd3
    } link_t;

    typedef enum logic [1:0] {
        PROV_IDLE      = 2'd0,
        PROV_ACTIVE    = 2'd1,
        PROV_SUCCEEDED = 2'd2,
        PROV_TIMED_OUT = 2'd3
    } prov_t;

    typedef enum logic [1:0] {
        UPD_IDLE      = 2'd0,
        UPD_RECEIVING = 2'd1,
        UPD_READY     = 2'd2
    } upd_t;

    localparam logic [1:0] OWNER_NONE    = 2'd0;
    localparam logic [1:0] OWNER_USB     = 2'd1;
    localparam logic [1:0] OWNER_NETWORK = 2'd2;

    typedef struct packed {
        logic  usb;
        link_t link;
        prov_t prov;
        upd_t  upd;
    } dev_state_t;

    typedef struct packed {
        status_t status;
        logic    wired_adv;
        logic    link_adv;
        logic    revoke;
    } step_flags_t;

endpackage

// ===== rtl/dmet_step.sv =====
// Guard checks, next-state logic and admission query for one request.
module dmet_step (
    input  dmet_pkg::dev_state_t  cur_state,
    input  logic [3:0]            opcode,
    input  logic [1:0]            claim_owner,
    input  logic                  authenticated,
    input  logic [1:0]            present_owner,
    output dmet_pkg::dev_state_t  next_state,
    output dmet_pkg::step_flags_t flags
);

    dmet_pkg::opcode_t op;
    dmet_pkg::status_t query_status;
    logic              ok;
    logic              wired_op;
    logic              link_op;

    assign op = dmet_pkg::opcode_t'(opcode);

    // Admission checks in priority order
    always_comb begin
        if (claim_owner == dmet_pkg::OWNER_NONE) begin
            query_status = dmet_pkg::ST_BAD_ARGUMENT;
        end else if (claim_owner == dmet_pkg::OWNER_NETWORK && !authenticated) begin
            query_status = dmet_pkg::ST_UNAUTH;
        end else if (cur_state.upd != dmet_pkg::UPD_IDLE) begin
            query_status = dmet_pkg::ST_BUSY;
        end else if (claim_owner == dmet_pkg::OWNER_NETWORK && cur_state.usb) begin
            query_status = dmet_pkg::ST_BUSY;
        end else if (claim_owner == dmet_pkg::OWNER_NETWORK
                     && cur_state.link != dmet_pkg::LINK_ONLINE) begin
            query_status = dmet_pkg::ST_OFFLINE;
        end else if (claim_owner != dmet_pkg::OWNER_NETWORK && !cur_state.usb) begin
            query_status = dmet_pkg::ST_OFFLINE;
        end else if (present_owner != dmet_pkg::OWNER_NONE
                     && present_owner != claim_owner) begin
            query_status = dmet_pkg::ST_BUSY;
        end else begin
            query_status = dmet_pkg::ST_OK;
        end
    end

    always_comb begin
        next_state = cur_state;
        ok         = 1'b1;
        wired_op   = 1'b0;
        link_op    = 1'b0;
        unique case (op)
            dmet_pkg::OP_USB_ATTACH: begin
                next_state.usb = 1'b1;
                wired_op       = 1'b1;
            end
            dmet_pkg::OP_USB_DETACH: begin
                next_state.usb = 1'b0;
                wired_op       = 1'b1;
            end
            dmet_pkg::OP_LINK_STOPPED: begin
                next_state.link = dmet_pkg::LINK_STOPPED;
                link_op         = 1'b1;
            end
            dmet_pkg::OP_LINK_DISCONN: begin
                link_op = 1'b1;
                if (cur_state.link == dmet_pkg::LINK_STOPPED) ok = 1'b0;
                else next_state.link = dmet_pkg::LINK_DISCONN;
            end
            dmet_pkg::OP_LINK_CONNECTING: begin
                next_state.link = dmet_pkg::LINK_CONNECTING;
                link_op         = 1'b1;
            end
            dmet_pkg::OP_LINK_ONLINE: begin
                link_op = 1'b1;
                if (cur_state.link != dmet_pkg::LINK_CONNECTING) ok = 1'b0;
                else next_state.link = dmet_pkg::LINK_ONLINE;
            end
            dmet_pkg::OP_PROV_START: begin
                if (cur_state.prov == dmet_pkg::PROV_ACTIVE) ok = 1'b0;
                else next_state.prov = dmet_pkg::PROV_ACTIVE;
            end
            dmet_pkg::OP_PROV_SUCCESS: begin
                if (cur_state.prov != dmet_pkg::PROV_ACTIVE) ok = 1'b0;
                else next_state.prov = dmet_pkg::PROV_SUCCEEDED;
            end
            dmet_pkg::OP_PROV_TIMEOUT: begin
                if (cur_state.prov != dmet_pkg::PROV_ACTIVE) ok = 1'b0;
                else next_state.prov = dmet_pkg::PROV_TIMED_OUT;
            end
            dmet_pkg::OP_PROV_RESET: begin
                next_state.prov = dmet_pkg::PROV_IDLE;
            end
            dmet_pkg::OP_UPD_START: begin
                wired_op = 1'b1;
                if (cur_state.upd != dmet_pkg::UPD_IDLE) ok = 1'b0;
                else next_state.upd = dmet_pkg::UPD_RECEIVING;
            end
            dmet_pkg::OP_UPD_ABORT, dmet_pkg::OP_UPD_FAIL: begin
                wired_op = 1'b1;
                if (cur_state.upd != dmet_pkg::UPD_RECEIVING) ok = 1'b0;
                else next_state.upd = dmet_pkg::UPD_IDLE;
            end
            dmet_pkg::OP_UPD_COMMIT: begin
                wired_op = 1'b1;
                if (cur_state.upd != dmet_pkg::UPD_RECEIVING) ok = 1'b0;
                else next_state.upd = dmet_pkg::UPD_READY;
            end
            dmet_pkg::OP_UPD_RESET: begin
                next_state.upd = dmet_pkg::UPD_IDLE;
                wired_op       = 1'b1;
            end
            dmet_pkg::OP_QUERY: begin
                next_state = cur_state;
            end
            default: begin
                next_state = cur_state;
            end
        endcase

        if (!ok) next_state = cur_state;
    end

    assign flags.status    = (op == dmet_pkg::OP_QUERY) ? query_status
                           : (ok ? dmet_pkg::ST_OK : dmet_pkg::ST_BAD_TRANSITION);
    assign flags.wired_adv = ok && wired_op;
    assign flags.link_adv  = ok && link_op;
    assign flags.revoke    = (op == dmet_pkg::OP_USB_ATTACH);

endmodule

// ===== rtl/device_mode_event_tracker_top.sv =====
// Top level of the device mode event tracker: state registers and result register.
// An accepted request's result is registered and shows on the m_ side in the next cycle.
// Throughput: one request per cycle while m_ready keeps the result register drained;
// the guard and update logic is a single pass between the state registers and the result register.
// s_ready stays high while the result register is empty or being drained.
// Reset (aresetn low, synchronous) clears the state, both epochs and m_valid.
module device_mode_event_tracker_top #(
    parameter int EPOCH_BITS = dmet_pkg::EPOCH_BITS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_opcode,
    input  logic [1:0] s_claim_owner,
    input  logic       s_authenticated,
    input  logic [1:0] s_present_owner,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic       m_usb_is_present,
    output logic [1:0] m_link_now,
    output logic [1:0] m_provisioning_now,
    output logic [1:0] m_update_now,
    output logic [7:0] m_wired_epoch_now,
    output logic [7:0] m_link_epoch_now,
    output logic       m_revoke_network
);

    localparam int OUT_BITS = dmet_pkg::EPOCH_OUT_BITS;

    dmet_pkg::dev_state_t  state_reg;
    dmet_pkg::dev_state_t  state_next;
    dmet_pkg::step_flags_t flags;

    logic [EPOCH_BITS-1:0] wired_epoch_reg;
    logic [EPOCH_BITS-1:0] wired_epoch_next;
    logic [EPOCH_BITS-1:0] link_epoch_reg;
    logic [EPOCH_BITS-1:0] link_epoch_next;
    logic [EPOCH_BITS+OUT_BITS-1:0] wired_ext;
    logic [EPOCH_BITS+OUT_BITS-1:0] link_ext;

    logic                  m_valid_reg;
    dmet_pkg::status_t     m_status_reg;
    dmet_pkg::dev_state_t  m_state_reg;
    logic [OUT_BITS-1:0]   m_wired_reg;
    logic [OUT_BITS-1:0]   m_link_reg;
    logic                  m_revoke_reg;

    logic s_fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    dmet_step u_step (
        .cur_state     (state_reg),
        .opcode        (s_opcode),
        .claim_owner   (s_claim_owner),
        .authenticated (s_authenticated),
        .present_owner (s_present_owner),
        .next_state    (state_next),
        .flags         (flags)
    );

    assign wired_epoch_next = wired_epoch_reg + EPOCH_BITS'(flags.wired_adv);
    assign link_epoch_next  = link_epoch_reg + EPOCH_BITS'(flags.link_adv);

    // widen before taking the low byte so narrow epochs zero-extend
    assign wired_ext = {{OUT_BITS{1'b0}}, wired_epoch_next};
    assign link_ext  = {{OUT_BITS{1'b0}}, link_epoch_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= '0;
            wired_epoch_reg <= '0;
            link_epoch_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg       <= state_next;
                wired_epoch_reg <= wired_epoch_next;
                link_epoch_reg  <= link_epoch_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_status_reg <= flags.status;
            m_state_reg  <= state_next;
            m_wired_reg  <= wired_ext[OUT_BITS-1:0];
            m_link_reg   <= link_ext[OUT_BITS-1:0];
            m_revoke_reg <= flags.revoke && (flags.status == dmet_pkg::ST_OK);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_usb_is_present   = m_state_reg.usb;
    assign m_link_now         = m_state_reg.link;
    assign m_provisioning_now = m_state_reg.prov;
    assign m_update_now       = m_state_reg.upd;
    assign m_wired_epoch_now  = m_wired_reg;
    assign m_link_epoch_now   = m_link_reg;
    assign m_revoke_network   = m_revoke_reg;

    // rejected events and queries leave state and epochs alone
    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (flags.status == dmet_pkg::ST_BAD_TRANSITION
                   || s_opcode == dmet_pkg::OP_QUERY)
        |=> $stable(state_reg) && $stable(wired_epoch_reg) && $stable(link_epoch_reg))
        else $error("state changed on rejected event or query");

    a_revoke_usb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_revoke_reg |-> m_state_reg.usb)
        else $error("revoke without usb present");

    a_upd_code: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.upd != 2'd3)
        else $error("update state reached unused code");

    a_wired_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && flags.wired_adv
        |=> wired_epoch_reg == $past(wired_epoch_reg) + EPOCH_BITS'(1))
        else $error("wired epoch did not advance by one");

    a_one_epoch: assert property (@(posedge aclk) disable iff (!aresetn)
        !(flags.wired_adv && flags.link_adv))
        else $error("both epochs advanced on one request");

endmodule

// ===== tb/device_mode_event_tracker_top_tb.sv =====
// Testbench for the device mode event tracker: directed table, random requests, scoreboard.
`timescale 1ns / 1ps

module device_mode_event_tracker_top_tb;

    localparam int          EPOCH_W      = dmet_pkg::EPOCH_BITS_DEFAULT;
    localparam int          NUM_DIRECTED = 26;
    localparam int          NUM_RANDOM   = 2000;
    localparam logic [1:0]  OWNER_DIAG   = 2'd3;

    typedef struct packed {
        dmet_pkg::status_t status;
        logic              usb;
        dmet_pkg::link_t   link;
        dmet_pkg::prov_t   prov;
        dmet_pkg::upd_t    upd;
        logic [7:0]        wired;
        logic [7:0]        lnk;
        logic              revoke;
    } tracker_result_t;

    typedef struct packed {
        dmet_pkg::opcode_t op;
        logic [1:0]        owner;
        logic              auth;
        logic [1:0]        holder;
        logic              typed;
        dmet_pkg::status_t status;
    } stim_row_t;

    logic       aclk;
    logic       aresetn           = 1'b0;
    logic       s_valid           = 1'b0;
    logic       s_ready;
    logic [3:0] s_opcode          = 4'd0;
    logic [1:0] s_claim_owner     = 2'd0;
    logic       s_authenticated   = 1'b0;
    logic [1:0] s_present_owner   = 2'd0;
    logic       m_valid;
    logic       m_ready           = 1'b0;
    logic [2:0] m_status;
    logic       m_usb_is_present;
    logic [1:0] m_link_now;
    logic [1:0] m_provisioning_now;
    logic [1:0] m_update_now;
    logic [7:0] m_wired_epoch_now;
    logic [7:0] m_link_epoch_now;
    logic       m_revoke_network;

    // typed-in status travelling with the request on the bus
    logic              cur_typed  = 1'b0;
    dmet_pkg::status_t cur_status = dmet_pkg::ST_OK;

    device_mode_event_tracker_top i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_claim_owner      (s_claim_owner),
        .s_authenticated    (s_authenticated),
        .s_present_owner    (s_present_owner),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_usb_is_present   (m_usb_is_present),
        .m_link_now         (m_link_now),
        .m_provisioning_now (m_provisioning_now),
        .m_update_now       (m_update_now),
        .m_wired_epoch_now  (m_wired_epoch_now),
        .m_link_epoch_now   (m_link_epoch_now),
        .m_revoke_network   (m_revoke_network)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #4ms;
        $display("Verification failed");
        $finish;
    end

    // ---------------- predictor state ----------------
    logic               trk_usb;
    dmet_pkg::link_t    trk_link;
    dmet_pkg::prov_t    trk_prov;
    dmet_pkg::upd_t     trk_upd;
    logic [EPOCH_W-1:0] trk_wired;
    logic [EPOCH_W-1:0] trk_lnk;

    tracker_result_t    expected_results[$];

    int errors       = 0;
    int n_requests   = 0;
    int n_results    = 0;
    int n_rejected   = 0;
    int n_queries    = 0;
    int n_allowed    = 0;
    int n_wraps      = 0;
    bit in_taken     = 1'b0;
    bit hold_off     = 1'b0;

    initial begin
        trk_usb   = 1'b0;
        trk_link  = dmet_pkg::LINK_STOPPED;
        trk_prov  = dmet_pkg::PROV_IDLE;
        trk_upd   = dmet_pkg::UPD_IDLE;
        trk_wired = '0;
        trk_lnk   = '0;
    end

    function automatic dmet_pkg::status_t admission_status(logic [1:0] owner, logic auth,
                                                           logic [1:0] holder);
        if (owner == dmet_pkg::OWNER_NONE)
            return dmet_pkg::ST_BAD_ARGUMENT;
        if (owner == dmet_pkg::OWNER_NETWORK && !auth)
            return dmet_pkg::ST_UNAUTH;
        if (trk_upd != dmet_pkg::UPD_IDLE)
            return dmet_pkg::ST_BUSY;
        if (owner == dmet_pkg::OWNER_NETWORK) begin
            if (trk_usb)
                return dmet_pkg::ST_BUSY;
            if (trk_link != dmet_pkg::LINK_ONLINE)
                return dmet_pkg::ST_OFFLINE;
        end else if (!trk_usb) begin
            return dmet_pkg::ST_OFFLINE;
        end
        if (holder != dmet_pkg::OWNER_NONE && holder != owner)
            return dmet_pkg::ST_BUSY;
        return dmet_pkg::ST_OK;
    endfunction

    task automatic track_request(input dmet_pkg::opcode_t op, input logic [1:0] owner,
                                 input logic auth, input logic [1:0] holder,
                                 output tracker_result_t res);
        logic              ok;
        dmet_pkg::status_t st;
        logic              revoke;
        ok     = 1'b1;
        st     = dmet_pkg::ST_OK;
        revoke = 1'b0;
        case (op)
            dmet_pkg::OP_USB_ATTACH:      trk_usb = 1'b1;
            dmet_pkg::OP_USB_DETACH:      trk_usb = 1'b0;
            dmet_pkg::OP_LINK_STOPPED:    trk_link = dmet_pkg::LINK_STOPPED;
            dmet_pkg::OP_LINK_DISCONN: begin
                if (trk_link == dmet_pkg::LINK_STOPPED) ok = 1'b0;
                else trk_link = dmet_pkg::LINK_DISCONN;
            end
            dmet_pkg::OP_LINK_CONNECTING: trk_link = dmet_pkg::LINK_CONNECTING;
            dmet_pkg::OP_LINK_ONLINE: begin
                if (trk_link != dmet_pkg::LINK_CONNECTING) ok = 1'b0;
                else trk_link = dmet_pkg::LINK_ONLINE;
            end
            dmet_pkg::OP_PROV_START: begin
                if (trk_prov == dmet_pkg::PROV_ACTIVE) ok = 1'b0;
                else trk_prov = dmet_pkg::PROV_ACTIVE;
            end
            dmet_pkg::OP_PROV_SUCCESS: begin
                if (trk_prov != dmet_pkg::PROV_ACTIVE) ok = 1'b0;
                else trk_prov = dmet_pkg::PROV_SUCCEEDED;
            end
            dmet_pkg::OP_PROV_TIMEOUT: begin
                if (trk_prov != dmet_pkg::PROV_ACTIVE) ok = 1'b0;
                else trk_prov = dmet_pkg::PROV_TIMED_OUT;
            end
            dmet_pkg::OP_PROV_RESET:      trk_prov = dmet_pkg::PROV_IDLE;
            dmet_pkg::OP_UPD_START: begin
                if (trk_upd != dmet_pkg::UPD_IDLE) ok = 1'b0;
                else trk_upd = dmet_pkg::UPD_RECEIVING;
            end
            dmet_pkg::OP_UPD_ABORT, dmet_pkg::OP_UPD_FAIL: begin
                if (trk_upd != dmet_pkg::UPD_RECEIVING) ok = 1'b0;
                else trk_upd = dmet_pkg::UPD_IDLE;
            end
            dmet_pkg::OP_UPD_COMMIT: begin
                if (trk_upd != dmet_pkg::UPD_RECEIVING) ok = 1'b0;
                else trk_upd = dmet_pkg::UPD_READY;
            end
            dmet_pkg::OP_UPD_RESET:       trk_upd = dmet_pkg::UPD_IDLE;
            default:                      st = admission_status(owner, auth, holder);
        endcase

        if (op != dmet_pkg::OP_QUERY) begin
            if (!ok) begin
                st = dmet_pkg::ST_BAD_TRANSITION;
            end else begin
                if (op <= dmet_pkg::OP_USB_DETACH || op >= dmet_pkg::OP_UPD_START) begin
                    trk_wired = trk_wired + EPOCH_W'(1);
                    if (trk_wired == '0) n_wraps++;
                end else if (op <= dmet_pkg::OP_LINK_ONLINE) begin
                    trk_lnk = trk_lnk + EPOCH_W'(1);
                    if (trk_lnk == '0) n_wraps++;
                end
                if (op == dmet_pkg::OP_USB_ATTACH) revoke = 1'b1;
            end
        end

        res.status = st;
        res.usb    = trk_usb;
        res.link   = trk_link;
        res.prov   = trk_prov;
        res.upd    = trk_upd;
        res.wired  = trk_wired[7:0];
        res.lnk    = trk_lnk[7:0];
        res.revoke = revoke;
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        errors++;
        $display("[%0t] mismatch on %s of result %0d: got %0h, want %0h",
                 $realtime, what, n_results, got, want);
    endtask

    // ---------------- monitor / scoreboard ----------------
    always @(posedge aclk) begin : monitor
        tracker_result_t want;
        if (aresetn) begin
            in_taken = s_valid && s_ready;
            if (in_taken) begin
                track_request(dmet_pkg::opcode_t'(s_opcode), s_claim_owner, s_authenticated,
                              s_present_owner, want);
                if (cur_typed) want.status = cur_status;
                if (want.status == dmet_pkg::ST_BAD_TRANSITION) n_rejected++;
                if (s_opcode == dmet_pkg::OP_QUERY) begin
                    n_queries++;
                    if (want.status == dmet_pkg::ST_OK) n_allowed++;
                end
                expected_results.push_back(want);
                n_requests++;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("presence (no request pending)", 8'd1, 8'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        flag_mismatch("status", 8'(m_status), 8'(want.status));
                    if (m_usb_is_present !== want.usb)
                        flag_mismatch("usb_is_present", 8'(m_usb_is_present),
                                      8'(want.usb));
                    if (m_link_now !== want.link)
                        flag_mismatch("link_now", 8'(m_link_now), 8'(want.link));
                    if (m_provisioning_now !== want.prov)
                        flag_mismatch("provisioning_now", 8'(m_provisioning_now),
                                      8'(want.prov));
                    if (m_update_now !== want.upd)
                        flag_mismatch("update_now", 8'(m_update_now), 8'(want.upd));
                    if (m_wired_epoch_now !== want.wired)
                        flag_mismatch("wired_epoch_now", m_wired_epoch_now, want.wired);
                    if (m_link_epoch_now !== want.lnk)
                        flag_mismatch("link_epoch_now", m_link_epoch_now, want.lnk);
                    if (m_revoke_network !== want.revoke)
                        flag_mismatch("revoke_network", 8'(m_revoke_network),
                                      8'(want.revoke));
                end
                n_results++;
            end
        end
    end

    // mostly no gap, sometimes a short one, rarely a long gap
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ---------------- receiver ----------------
    int rx_wait  = 0;
    int rx_burst = 0;

    always @(negedge aclk) begin
        if (hold_off || !aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            m_ready <= 1'b0;
            rx_wait--;
        end else begin
            m_ready <= 1'b1;
            if (rx_burst > 0) begin
                rx_burst--;
            end else begin
                rx_wait = pick_gap();
                if ($urandom_range(0, 199) == 0) rx_burst = $urandom_range(40, 120);
            end
        end
    end

    // long receiver stall while requests keep coming, fills the result register
    initial begin
        wait (n_requests >= 600);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (150) @(posedge aclk);
        hold_off = 1'b0;
    end

    // ---------------- sender ----------------
    int tx_burst = 0;

    task automatic offer_request(input stim_row_t row);
        int gap;
        if (tx_burst > 0) begin
            gap = 0;
            tx_burst--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 199) == 0) tx_burst = $urandom_range(40, 120);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= row.op;
        s_claim_owner   <= row.owner;
        s_authenticated <= row.auth;
        s_present_owner <= row.holder;
        cur_typed       <= row.typed;
        cur_status      <= row.status;
        do @(negedge aclk); while (!in_taken);
    endtask

    stim_row_t directed_rows [NUM_DIRECTED];

    initial begin : stimulus
        stim_row_t row;
        int        r;
        directed_rows = '{
            // fresh after reset: query argument and auth errors, then offline
            '{dmet_pkg::OP_QUERY, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_BAD_ARGUMENT},
            '{dmet_pkg::OP_QUERY, dmet_pkg::OWNER_NETWORK, 1'b0, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_UNAUTH},
            '{dmet_pkg::OP_QUERY, dmet_pkg::OWNER_USB, 1'b1, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_OFFLINE},
            '{dmet_pkg::OP_QUERY, dmet_pkg::OWNER_NETWORK, 1'b1, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_OFFLINE},
            // guarded events from reset state
            '{dmet_pkg::OP_LINK_DISCONN, OWNER_DIAG, 1'b1, OWNER_DIAG,
              1'b1, dmet_pkg::ST_BAD_TRANSITION},
            '{dmet_pkg::OP_LINK_ONLINE, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_BAD_TRANSITION},
            '{dmet_pkg::OP_PROV_SUCCESS, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_BAD_TRANSITION},
            '{dmet_pkg::OP_PROV_TIMEOUT, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_BAD_TRANSITION},
            '{dmet_pkg::OP_UPD_ABORT, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_BAD_TRANSITION},
            '{dmet_pkg::OP_UPD_FAIL, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_BAD_TRANSITION},
            '{dmet_pkg::OP_UPD_COMMIT, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_BAD_TRANSITION},
            // usb attached: network busy, foreign holder busy, usb allowed
            '{dmet_pkg::OP_USB_ATTACH, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b0, dmet_pkg::ST_OK},
            '{dmet_pkg::OP_QUERY, dmet_pkg::OWNER_NETWORK, 1'b1, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_BUSY},
            '{dmet_pkg::OP_QUERY, OWNER_DIAG, 1'b0, dmet_pkg::OWNER_NETWORK,
              1'b1, dmet_pkg::ST_BUSY},
            '{dmet_pkg::OP_QUERY, dmet_pkg::OWNER_USB, 1'b0, dmet_pkg::OWNER_USB,
              1'b1, dmet_pkg::ST_OK},
            // update in progress blocks queries and a second start
            '{dmet_pkg::OP_UPD_START, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b0, dmet_pkg::ST_OK},
            '{dmet_pkg::OP_QUERY, dmet_pkg::OWNER_USB, 1'b1, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_BUSY},
            '{dmet_pkg::OP_UPD_START, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b1, dmet_pkg::ST_BAD_TRANSITION},
            '{dmet_pkg::OP_UPD_COMMIT, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b0, dmet_pkg::ST_OK},
            '{dmet_pkg::OP_UPD_RESET, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b0, dmet_pkg::ST_OK},
            // unguarded detach twice still advances the epoch
            '{dmet_pkg::OP_USB_DETACH, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b0, dmet_pkg::ST_OK},
            '{dmet_pkg::OP_USB_DETACH, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b0, dmet_pkg::ST_OK},
            '{dmet_pkg::OP_LINK_CONNECTING, dmet_pkg::OWNER_NONE, 1'b0,
              dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::ST_OK},
            '{dmet_pkg::OP_LINK_ONLINE, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b0, dmet_pkg::ST_OK},
            '{dmet_pkg::OP_QUERY, dmet_pkg::OWNER_NETWORK, 1'b1, dmet_pkg::OWNER_NETWORK,
              1'b1, dmet_pkg::ST_OK},
            '{dmet_pkg::OP_PROV_START, dmet_pkg::OWNER_NONE, 1'b0, dmet_pkg::OWNER_NONE,
              1'b0, dmet_pkg::ST_OK}
        };

        wait (aresetn);
        @(negedge aclk);

        foreach (directed_rows[i])
            offer_request(directed_rows[i]);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            row.op     = (r < 25) ? dmet_pkg::OP_QUERY
                                  : dmet_pkg::opcode_t'($urandom_range(0, 14));
            row.owner  = 2'($urandom_range(0, 3));
            row.auth   = 1'($urandom_range(0, 1));
            row.holder = 2'($urandom_range(0, 3));
            row.typed  = 1'b0;
            row.status = dmet_pkg::ST_OK;
            offer_request(row);
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Run covered %0d requests, %0d results: %0d queries (%0d allowed), %0d rejected",
                 n_requests, n_results, n_queries, n_allowed, n_rejected);
        $display("Epoch counters wrapped %0d times; %0d mismatches", n_wraps, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
